[rtl/cptw_pkg.sv]
// shared constants and types for the closest point triangle weights block
package cptw_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // voronoi region codes of the closest point
  typedef enum logic [2:0] {
    REG_A    = 3'd0,
    REG_B    = 3'd1,
    REG_AB   = 3'd2,
    REG_C    = 3'd3,
    REG_AC   = 3'd4,
    REG_BC   = 3'd5,
    REG_FACE = 3'd6
  } region_t;

endpackage

[rtl/cptw_if.sv]
// valid/ready channel interfaces for queries and results
interface cptw_in_if #(
  parameter int COORD_WIDTH = cptw_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z;
  logic signed [COORD_WIDTH-1:0] b_x, b_y, b_z;
  logic signed [COORD_WIDTH-1:0] c_x, c_y, c_z;
  logic signed [COORD_WIDTH-1:0] p_x, p_y, p_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  p_x, p_y, p_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                p_x, p_y, p_z, output ready);
endinterface

interface cptw_out_if #(
  parameter int FRACTION_BITS = cptw_pkg::FRACTION_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [FRACTION_BITS:0] weight_a;
  logic [FRACTION_BITS:0] weight_b;
  logic [FRACTION_BITS:0] weight_c;
  cptw_pkg::region_t      region;
  logic                   degenerate;

  modport source (output valid, weight_a, weight_b, weight_c, region, degenerate,
                  input ready);
  modport sink (input valid, weight_a, weight_b, weight_c, region, degenerate,
                output ready);
endinterface

[rtl/closest_point_triangle_weights.sv]
// from input transfer, a query passes front, region, divider and output register stages
// throughput: one query per cycle unless out_ch stalls; every stage advances when it is
//   empty or its successor advances, so idle stages keep filling while a result waits
// the divider takes one quotient bit per stage and sets most of the depth
// reset clears the stage valid bits only; payload registers are not reset
module closest_point_triangle_weights #(
  parameter int COORD_WIDTH   = cptw_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = cptw_pkg::FRACTION_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  cptw_in_if.sink    in_ch,
  cptw_out_if.source out_ch
);

  localparam int DOTW = 2 * (COORD_WIDTH + 1) + 2;
  localparam int NW   = 2 * DOTW + 3;
  localparam int F    = FRACTION_BITS;
  localparam int NS   = F + 9;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  logic [NS-1:0] v_in;

  logic signed [COORD_WIDTH-1:0] a_c [3], b_c [3], c_c [3], p_c [3];
  logic signed [DOTW-1:0]        d    [6];
  logic signed [NW-1:0]          num  [3];
  logic signed [NW-1:0]          den  [3];
  cptw_pkg::region_t             region_s;
  logic [F:0]                    q    [3];
  logic [2:0]                    dz;
  cptw_pkg::region_t             region_q;

  logic [F:0]        wa_c, wb_c, wc_c;
  logic              deg_c;
  logic [F:0]        wa_r, wb_r, wc_r;
  logic              deg_r;
  cptw_pkg::region_t region_r;

  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  // stage advance chain from the output back
  assign en[NS-1] = !v_r[NS-1] || out_ch.ready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  assign v_in = {v_r[NS-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (en & v_in) | (~en & v_r);
    end
  end

  assign in_ch.ready = en[0];

  // query coordinates as vectors
  assign a_c[0] = in_ch.a_x;
  assign a_c[1] = in_ch.a_y;
  assign a_c[2] = in_ch.a_z;
  assign b_c[0] = in_ch.b_x;
  assign b_c[1] = in_ch.b_y;
  assign b_c[2] = in_ch.b_z;
  assign c_c[0] = in_ch.c_x;
  assign c_c[1] = in_ch.c_y;
  assign c_c[2] = in_ch.c_z;
  assign p_c[0] = in_ch.p_x;
  assign p_c[1] = in_ch.p_y;
  assign p_c[2] = in_ch.p_z;

  cptw_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .en(en[2:0]), .a_i(a_c), .b_i(b_c), .c_i(c_c), .p_i(p_c), .d_o(d)
  );

  cptw_region #(.COORD_WIDTH(COORD_WIDTH)) u_region (
    .clk, .en(en[6:3]), .d_i(d), .num_o(num), .den_o(den), .region_o(region_s)
  );

  cptw_div #(.NW(NW), .FRACTION_BITS(F)) u_div (
    .clk, .en(en[F+7:7]), .num_i(num), .den_i(den), .region_i(region_s),
    .q_o(q), .dz_o(dz), .region_o(region_q)
  );

  // weights per region
  always_comb begin
    wa_c  = '0;
    wb_c  = '0;
    wc_c  = '0;
    deg_c = 1'b0;
    unique case (region_q)
      cptw_pkg::REG_A: wa_c = ONE;
      cptw_pkg::REG_B: wb_c = ONE;
      cptw_pkg::REG_C: wc_c = ONE;
      cptw_pkg::REG_AB: begin
        wb_c  = q[0];
        wa_c  = ONE - q[0];
        deg_c = dz[0];
      end
      cptw_pkg::REG_AC: begin
        wc_c  = q[0];
        wa_c  = ONE - q[0];
        deg_c = dz[0];
      end
      cptw_pkg::REG_BC: begin
        wc_c  = q[0];
        wb_c  = ONE - q[0];
        deg_c = dz[0];
      end
      cptw_pkg::REG_FACE: begin
        wa_c  = q[0];
        wb_c  = q[1];
        wc_c  = q[2];
        deg_c = |dz;
      end
      default: begin
        wa_c = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      wa_r     <= wa_c;
      wb_r     <= wb_c;
      wc_r     <= wc_c;
      deg_r    <= deg_c;
      region_r <= region_q;
    end
  end

  assign out_ch.valid      = v_r[NS-1];
  assign out_ch.weight_a   = wa_r;
  assign out_ch.weight_b   = wb_r;
  assign out_ch.weight_c   = wc_r;
  assign out_ch.degenerate = deg_r;
  assign out_ch.region     = region_r;

  // input is only held off when a result is waiting
  a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no result pending");

  // vertex regions never flag a zero divisor
  a_vertex_deg: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.region == cptw_pkg::REG_A || out_ch.region == cptw_pkg::REG_B
                     || out_ch.region == cptw_pkg::REG_C) |-> !out_ch.degenerate)
    else $error("degenerate flag in vertex region");

  // edge weights sum to one
  a_edge_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.region == cptw_pkg::REG_AB || out_ch.region == cptw_pkg::REG_AC
                     || out_ch.region == cptw_pkg::REG_BC)
    |-> ((F + 3)'(out_ch.weight_a) + (F + 3)'(out_ch.weight_b)
         + (F + 3)'(out_ch.weight_c)) == (F + 3)'(ONE))
    else $error("edge weights do not sum to one");

  // vertex a gives a unit weight at a alone
  a_vertex_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.region == cptw_pkg::REG_A
    |-> out_ch.weight_a == ONE && out_ch.weight_b == '0 && out_ch.weight_c == '0)
    else $error("vertex a weights wrong");

endmodule

[rtl/cptw_front.sv]
// edge vectors and the six dot products, three register stages
module cptw_front #(
  parameter int  COORD_WIDTH = cptw_pkg::COORD_WIDTH_DEF,
  localparam int DOTW        = 2 * (COORD_WIDTH + 1) + 2
) (
  input  logic                          clk,
  input  logic [2:0]                    en,
  input  logic signed [COORD_WIDTH-1:0] a_i [3],
  input  logic signed [COORD_WIDTH-1:0] b_i [3],
  input  logic signed [COORD_WIDTH-1:0] c_i [3],
  input  logic signed [COORD_WIDTH-1:0] p_i [3],
  output logic signed [DOTW-1:0]        d_o [6]
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  // difference vectors: ab, ac, ap, bp, cp
  logic signed [DW-1:0]   diff_r [5][3];
  logic signed [PW-1:0]   prod_r [6][3];
  logic signed [DOTW-1:0] dot_r  [6];

  // stage 1: coordinate differences
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        diff_r[0][i] <= DW'(b_i[i]) - DW'(a_i[i]);
        diff_r[1][i] <= DW'(c_i[i]) - DW'(a_i[i]);
        diff_r[2][i] <= DW'(p_i[i]) - DW'(a_i[i]);
        diff_r[3][i] <= DW'(p_i[i]) - DW'(b_i[i]);
        diff_r[4][i] <= DW'(p_i[i]) - DW'(c_i[i]);
      end
    end
  end

  // stage 2: component products, dot k pairs ab/ac with ap, bp, cp
  for (genvar k = 0; k < 6; k++) begin : g_dot
    localparam int U = k % 2;
    localparam int V = 2 + k / 2;

    always_ff @(posedge clk) begin
      if (en[1]) begin
        for (int i = 0; i < 3; i++) begin
          prod_r[k][i] <= diff_r[U][i] * diff_r[V][i];
        end
      end
    end

    // stage 3: sum of the three components
    always_ff @(posedge clk) begin
      if (en[2]) begin
        dot_r[k] <= DOTW'(prod_r[k][0]) + DOTW'(prod_r[k][1]) + DOTW'(prod_r[k][2]);
      end
    end

    assign d_o[k] = dot_r[k];
  end

endmodule

[rtl/cptw_wmul.sv]
// two-stage signed multiplier built from four half-width partial products
module cptw_wmul #(
  parameter int  W = 2 * (cptw_pkg::COORD_WIDTH_DEF + 1) + 2,
  localparam int P = 2 * W
) (
  input  logic                clk,
  input  logic [1:0]          en,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic signed [P-1:0] p
);

  localparam int H = W / 2;
  localparam int L = W - H;

  logic [H-1:0]        al, bl;
  logic signed [L-1:0] ah, bh;

  logic signed [2*L-1:0] hh_r;
  logic signed [L+H:0]   hl_r, lh_r;
  logic [2*H-1:0]        ll_r;
  logic signed [P-1:0]   p_r;

  assign al = a[H-1:0];
  assign bl = b[H-1:0];
  assign ah = a[W-1:H];
  assign bh = b[W-1:H];

  // partial products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      hh_r <= ah * bh;
      hl_r <= ah * $signed({1'b0, bl});
      lh_r <= $signed({1'b0, al}) * bh;
      ll_r <= al * bl;
    end
  end

  // weighted sum of the partials
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_r <= (P'(hh_r) <<< (2 * H)) + ((P'(hl_r) + P'(lh_r)) <<< H)
             + $signed({{(P - 2 * H){1'b0}}, ll_r});
    end
  end

  assign p = p_r;

endmodule

[rtl/cptw_region.sv]
// region tests, 2x2 determinants and quotient operand selection
module cptw_region #(
  parameter int  COORD_WIDTH = cptw_pkg::COORD_WIDTH_DEF,
  localparam int DOTW        = 2 * (COORD_WIDTH + 1) + 2,
  localparam int NW          = 2 * DOTW + 3
) (
  input  logic                   clk,
  input  logic [3:0]             en,
  input  logic signed [DOTW-1:0] d_i [6],
  output logic signed [NW-1:0]   num_o [3],
  output logic signed [NW-1:0]   den_o [3],
  output cptw_pkg::region_t      region_o
);

  localparam int EW = DOTW + 2;
  localparam int VW = 2 * DOTW + 1;
  localparam int PW = 2 * DOTW;

  typedef struct packed {
    logic t_a;
    logic t_b;
    logic e_ab;
    logic t_c;
    logic e_ac;
    logic e_bc;
  } rtest_t;

  rtest_t               tst_c;
  logic signed [EW-1:0] enum_c [3];
  logic signed [EW-1:0] eden_c [3];
  logic signed [DOTW:0] s43, s56;

  rtest_t               tst_r  [3];
  logic signed [EW-1:0] enum_r [3][3];
  logic signed [EW-1:0] eden_r [3][3];

  logic signed [PW-1:0] prod [6];
  logic signed [VW-1:0] v_r  [3];

  logic signed [NW-1:0] num_c [3];
  logic signed [NW-1:0] den_c [3];
  cptw_pkg::region_t    region_c;

  logic signed [NW-1:0] num_r [3];
  logic signed [NW-1:0] den_r [3];
  cptw_pkg::region_t    region_r;

  // tests and edge operands that need only the dot products
  always_comb begin
    s43       = (DOTW + 1)'(d_i[3]) - (DOTW + 1)'(d_i[2]);
    s56       = (DOTW + 1)'(d_i[4]) - (DOTW + 1)'(d_i[5]);
    tst_c.t_a  = (d_i[0] <= 0) && (d_i[1] <= 0);
    tst_c.t_b  = (d_i[2] >= 0) && (s43 <= 0);
    tst_c.e_ab = (d_i[0] >= 0) && (d_i[2] <= 0);
    tst_c.t_c  = (d_i[5] >= 0) && (s56 <= 0);
    tst_c.e_ac = (d_i[1] >= 0) && (d_i[5] <= 0);
    tst_c.e_bc = (s43 >= 0) && (s56 >= 0);
    enum_c[0] = EW'(d_i[0]);
    eden_c[0] = EW'(d_i[0]) - EW'(d_i[2]);
    enum_c[1] = EW'(d_i[1]);
    eden_c[1] = EW'(d_i[1]) - EW'(d_i[5]);
    enum_c[2] = EW'(s43);
    eden_c[2] = EW'(s43) + EW'(s56);
  end

  // carry tests alongside the multiplier stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      tst_r[0]  <= tst_c;
      enum_r[0] <= enum_c;
      eden_r[0] <= eden_c;
    end
    if (en[1]) begin
      tst_r[1]  <= tst_r[0];
      enum_r[1] <= enum_r[0];
      eden_r[1] <= eden_r[0];
    end
    if (en[2]) begin
      tst_r[2]  <= tst_r[1];
      enum_r[2] <= enum_r[1];
      eden_r[2] <= eden_r[1];
    end
  end

  // determinant products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  cptw_wmul #(.W(DOTW)) u_mul0 (.clk, .en(en[1:0]), .a(d_i[0]), .b(d_i[3]), .p(prod[0]));
  cptw_wmul #(.W(DOTW)) u_mul1 (.clk, .en(en[1:0]), .a(d_i[2]), .b(d_i[1]), .p(prod[1]));
  cptw_wmul #(.W(DOTW)) u_mul2 (.clk, .en(en[1:0]), .a(d_i[4]), .b(d_i[1]), .p(prod[2]));
  cptw_wmul #(.W(DOTW)) u_mul3 (.clk, .en(en[1:0]), .a(d_i[0]), .b(d_i[5]), .p(prod[3]));
  cptw_wmul #(.W(DOTW)) u_mul4 (.clk, .en(en[1:0]), .a(d_i[2]), .b(d_i[5]), .p(prod[4]));
  cptw_wmul #(.W(DOTW)) u_mul5 (.clk, .en(en[1:0]), .a(d_i[4]), .b(d_i[3]), .p(prod[5]));

  // va, vb, vc
  always_ff @(posedge clk) begin
    if (en[2]) begin
      v_r[0] <= VW'(prod[4]) - VW'(prod[5]);
      v_r[1] <= VW'(prod[2]) - VW'(prod[3]);
      v_r[2] <= VW'(prod[0]) - VW'(prod[1]);
    end
  end

  // region decision in test order; edges use lane 0
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num_c[l] = NW'(v_r[l]);
      den_c[l] = NW'(v_r[0]) + NW'(v_r[1]) + NW'(v_r[2]);
    end
    region_c = cptw_pkg::REG_FACE;
    priority if (tst_r[2].t_a) begin
      region_c = cptw_pkg::REG_A;
    end else if (tst_r[2].t_b) begin
      region_c = cptw_pkg::REG_B;
    end else if ((v_r[2] <= 0) && tst_r[2].e_ab) begin
      region_c = cptw_pkg::REG_AB;
      num_c[0] = NW'(enum_r[2][0]);
      den_c[0] = NW'(eden_r[2][0]);
    end else if (tst_r[2].t_c) begin
      region_c = cptw_pkg::REG_C;
    end else if ((v_r[1] <= 0) && tst_r[2].e_ac) begin
      region_c = cptw_pkg::REG_AC;
      num_c[0] = NW'(enum_r[2][1]);
      den_c[0] = NW'(eden_r[2][1]);
    end else if ((v_r[0] <= 0) && tst_r[2].e_bc) begin
      region_c = cptw_pkg::REG_BC;
      num_c[0] = NW'(enum_r[2][2]);
      den_c[0] = NW'(eden_r[2][2]);
    end else begin
      region_c = cptw_pkg::REG_FACE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      num_r    <= num_c;
      den_r    <= den_c;
      region_r <= region_c;
    end
  end

  assign num_o    = num_r;
  assign den_o    = den_r;
  assign region_o = region_r;

endmodule

[rtl/cptw_div.sv]
// three-lane restoring divider, one quotient bit per stage
module cptw_div #(
  parameter int  NW            = 4 * (cptw_pkg::COORD_WIDTH_DEF + 1) + 7,
  parameter int  FRACTION_BITS = cptw_pkg::FRACTION_BITS_DEF,
  localparam int NS            = FRACTION_BITS + 1
) (
  input  logic                     clk,
  input  logic [NS-1:0]            en,
  input  logic signed [NW-1:0]     num_i [3],
  input  logic signed [NW-1:0]     den_i [3],
  input  cptw_pkg::region_t        region_i,
  output logic [FRACTION_BITS:0]   q_o [3],
  output logic [2:0]               dz_o,
  output cptw_pkg::region_t        region_o
);

  localparam int F = FRACTION_BITS;

  logic [NW-1:0]     rem_r  [F][3];
  logic [NW-1:0]     dv_r   [F][3];
  logic [F-1:0]      q_r    [NS][3];
  logic [2:0]        zero_r [NS];
  logic [2:0]        dz_r   [NS];
  logic [2:0]        sat_r  [F];
  cptw_pkg::region_t reg_r  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_prep
      // magnitudes and the zero-divisor / opposite-sign cases
      always_ff @(posedge clk) begin
        if (en[0]) begin
          reg_r[0] <= region_i;
          for (int l = 0; l < 3; l++) begin
            rem_r[0][l]  <= num_i[l][NW-1] ? $unsigned(-num_i[l]) : $unsigned(num_i[l]);
            dv_r[0][l]   <= den_i[l][NW-1] ? $unsigned(-den_i[l]) : $unsigned(den_i[l]);
            dz_r[0][l]   <= (den_i[l] == 0);
            zero_r[0][l] <= (num_i[l] == 0) || (num_i[l][NW-1] != den_i[l][NW-1]);
            q_r[0][l]    <= '0;
          end
        end
      end
    end else begin : g_step
      logic [NW:0] r2  [3];
      logic [NW:0] sub [3];
      logic [2:0]  ge;

      // shift, compare and conditional subtract
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          r2[l]  = {rem_r[s-1][l], 1'b0};
          sub[l] = r2[l] - {1'b0, dv_r[s-1][l]};
          ge[l]  = (r2[l] >= {1'b0, dv_r[s-1][l]});
        end
      end

      always_ff @(posedge clk) begin
        if (en[s]) begin
          reg_r[s]  <= reg_r[s-1];
          dz_r[s]   <= dz_r[s-1];
          zero_r[s] <= zero_r[s-1];
          for (int l = 0; l < 3; l++) begin
            q_r[s][l] <= {q_r[s-1][l][F-2:0], ge[l]};
          end
        end
      end

      if (s < F) begin : g_rem
        always_ff @(posedge clk) begin
          if (en[s]) begin
            for (int l = 0; l < 3; l++) begin
              rem_r[s][l] <= ge[l] ? sub[l][NW-1:0] : r2[l][NW-1:0];
              dv_r[s][l]  <= dv_r[s-1][l];
            end
          end
        end
      end

      // quotient of one or more saturates
      if (s == 1) begin : g_sat_first
        always_ff @(posedge clk) begin
          if (en[s]) begin
            for (int l = 0; l < 3; l++) begin
              sat_r[0][l] <= (rem_r[0][l] >= dv_r[0][l]);
            end
          end
        end
      end else begin : g_sat_pass
        always_ff @(posedge clk) begin
          if (en[s]) begin
            sat_r[s-1] <= sat_r[s-2];
          end
        end
      end
    end
  end

  // final quotient with zero and saturation cases
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dz_r[NS-1][l] || zero_r[NS-1][l]) begin
        q_o[l] = '0;
      end else if (sat_r[F-1][l]) begin
        q_o[l] = {1'b1, {F{1'b0}}};
      end else begin
        q_o[l] = {1'b0, q_r[NS-1][l]};
      end
    end
  end

  assign dz_o     = dz_r[NS-1];
  assign region_o = reg_r[NS-1];

endmodule

[bench/testbench.sv]
// testbench for the closest point triangle weights block: directed table, then random queries
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [127:0] wide_t;

  // one query: a, b, c, p as x y z in that order
  typedef struct {
    logic signed [15:0] crd [12];
    bit                 has_exp;
    logic [16:0]        exp_a, exp_b, exp_c;
    cptw_pkg::region_t  exp_reg;
    bit                 exp_deg;
  } query_t;

  typedef struct {
    logic [16:0]       wa, wb, wc;
    cptw_pkg::region_t reg_code;
    bit                deg;
  } weights_t;

  // one row of the directed table
  typedef struct {
    int                crd [12];
    bit                has_exp;
    logic [16:0]       wa, wb, wc;
    cptw_pkg::region_t rg;
    bit                dg;
  } dir_row_t;

  localparam logic [16:0] ONE  = 17'h10000;
  localparam logic [16:0] HALF = 17'h08000;
  localparam logic [16:0] ZERO = 17'h00000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cptw_in_if  in_ch ();
  cptw_out_if out_ch ();

  closest_point_triangle_weights dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // directed rows; expectations only where they are obvious
  dir_row_t dir_tab [18] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      1'b1, ONE, ZERO, ZERO, cptw_pkg::REG_A, 1'b0},
    '{'{0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 0},
      1'b1, ONE, ZERO, ZERO, cptw_pkg::REG_A, 1'b0},
    '{'{0, 0, 0, 100, 0, 0, 0, 100, 0, 100, 0, 0},
      1'b1, ZERO, ONE, ZERO, cptw_pkg::REG_B, 1'b0},
    '{'{0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 100, 0},
      1'b1, ZERO, ZERO, ONE, cptw_pkg::REG_C, 1'b0},
    '{'{0, 0, 0, 100, 0, 0, 0, 100, 0, -50, -50, 7},
      1'b1, ONE, ZERO, ZERO, cptw_pkg::REG_A, 1'b0},
    '{'{0, 0, 0, 100, 0, 0, 0, 100, 0, 50, -20, 0},
      1'b1, HALF, HALF, ZERO, cptw_pkg::REG_AB, 1'b0},
    '{'{0, 0, 0, 100, 0, 0, 0, 100, 0, -20, 25, 3},
      1'b0, ZERO, ZERO, ZERO, cptw_pkg::REG_FACE, 1'b0},
    '{'{0, 0, 0, 100, 0, 0, 0, 100, 0, 80, 80, -9},
      1'b0, ZERO, ZERO, ZERO, cptw_pkg::REG_FACE, 1'b0},
    '{'{0, 0, 0, 100, 0, 0, 0, 100, 0, 20, 30, 40},
      1'b0, ZERO, ZERO, ZERO, cptw_pkg::REG_FACE, 1'b0},
    '{'{-32768, -32768, -32768, 32767, -32768, -32768,
        -32768, 32767, -32768, 0, 0, 32767},
      1'b0, ZERO, ZERO, ZERO, cptw_pkg::REG_FACE, 1'b0},
    '{'{32767, 32767, 32767, -32768, 32767, 32767,
        32767, -32768, 32767, -32768, -32768, -32768},
      1'b0, ZERO, ZERO, ZERO, cptw_pkg::REG_FACE, 1'b0},
    '{'{-32768, 32767, -32768, 32767, -32768, 32767,
        -32768, -32768, 32767, 32767, 32767, -32768},
      1'b0, ZERO, ZERO, ZERO, cptw_pkg::REG_FACE, 1'b0},
    '{'{32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767, 1, 1, -32768},
      1'b0, ZERO, ZERO, ZERO, cptw_pkg::REG_FACE, 1'b0},
    // collinear triangle, p beyond the face
    '{'{0, 0, 0, 10, 0, 0, 20, 0, 0, 5, 5, 5},
      1'b0, ZERO, ZERO, ZERO, cptw_pkg::REG_FACE, 1'b0},
    '{'{0, 0, 0, 10, 10, 10, -10, -10, -10, 3, -4, 1},
      1'b0, ZERO, ZERO, ZERO, cptw_pkg::REG_FACE, 1'b0},
    // all vertices equal, p elsewhere
    '{'{7, 7, 7, 7, 7, 7, 7, 7, 7, 9, -3, 2},
      1'b0, ZERO, ZERO, ZERO, cptw_pkg::REG_FACE, 1'b0},
    // a and b equal, c apart
    '{'{1, 2, 3, 1, 2, 3, 50, 2, 3, 20, 40, 3},
      1'b0, ZERO, ZERO, ZERO, cptw_pkg::REG_FACE, 1'b0},
    '{'{0, 0, 0, 0, 0, 0, 0, 64, 0, 30, 10, 0},
      1'b0, ZERO, ZERO, ZERO, cptw_pkg::REG_FACE, 1'b0}
  };

  query_t   query_q [$];
  weights_t weights_q [$];
  query_t   cur;
  int       gap_left = 0;
  int       burst_left = 4;
  int       errors = 0;
  int       results_seen = 0;
  int       stall_mode = 0;
  int       mode_cnt = 0;
  int       region_hits [7];

  // truncated quotient num/den in q1.16, saturated to zero and one
  function automatic logic [16:0] div_weight(wide_t num, wide_t den, inout bit deg);
    wide_t       rem, dv;
    logic [16:0] q;
    q = '0;
    if (den == 0) begin
      deg = 1'b1;
      return '0;
    end
    if (num == 0 || (num < 0) != (den < 0)) return '0;
    rem = (num < 0) ? -num : num;
    dv  = (den < 0) ? -den : den;
    if (rem >= dv) return ONE;
    for (int i = 0; i < 16; i++) begin
      rem = rem * 2;
      q   = q << 1;
      if (rem >= dv) begin
        rem  = rem - dv;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // voronoi region tests and clamped weights of the closest point
  function automatic weights_t predict_weights(query_t q);
    longint   ab [3], ac [3], ap [3], bp [3], cp [3];
    longint   d1, d2, d3, d4, d5, d6;
    wide_t    va, vb, vc, nsum;
    weights_t r;
    bit       deg;
    deg = 1'b0;
    d1 = 0; d2 = 0; d3 = 0; d4 = 0; d5 = 0; d6 = 0;
    for (int i = 0; i < 3; i++) begin
      ab[i] = longint'(q.crd[3+i]) - longint'(q.crd[i]);
      ac[i] = longint'(q.crd[6+i]) - longint'(q.crd[i]);
      ap[i] = longint'(q.crd[9+i]) - longint'(q.crd[i]);
      bp[i] = longint'(q.crd[9+i]) - longint'(q.crd[3+i]);
      cp[i] = longint'(q.crd[9+i]) - longint'(q.crd[6+i]);
      d1 += ab[i] * ap[i]; d2 += ac[i] * ap[i];
      d3 += ab[i] * bp[i]; d4 += ac[i] * bp[i];
      d5 += ab[i] * cp[i]; d6 += ac[i] * cp[i];
    end
    vc = wide_t'(d1) * wide_t'(d4) - wide_t'(d3) * wide_t'(d2);
    vb = wide_t'(d5) * wide_t'(d2) - wide_t'(d1) * wide_t'(d6);
    va = wide_t'(d3) * wide_t'(d6) - wide_t'(d5) * wide_t'(d4);
    r.wa = '0; r.wb = '0; r.wc = '0;
    if (d1 <= 0 && d2 <= 0) begin
      r.wa = ONE; r.reg_code = cptw_pkg::REG_A;
    end else if (d3 >= 0 && d4 - d3 <= 0) begin
      r.wb = ONE; r.reg_code = cptw_pkg::REG_B;
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      r.wb = div_weight(wide_t'(d1), wide_t'(d1 - d3), deg);
      r.wa = ONE - r.wb; r.reg_code = cptw_pkg::REG_AB;
    end else if (d6 >= 0 && d5 - d6 <= 0) begin
      r.wc = ONE; r.reg_code = cptw_pkg::REG_C;
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      r.wc = div_weight(wide_t'(d2), wide_t'(d2 - d6), deg);
      r.wa = ONE - r.wc; r.reg_code = cptw_pkg::REG_AC;
    end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
      r.wc = div_weight(wide_t'(d4 - d3), wide_t'(d4 - d3) + wide_t'(d5 - d6), deg);
      r.wb = ONE - r.wc; r.reg_code = cptw_pkg::REG_BC;
    end else begin
      nsum = va + vb + vc;
      r.wa = div_weight(va, nsum, deg);
      r.wb = div_weight(vb, nsum, deg);
      r.wc = div_weight(vc, nsum, deg);
      r.reg_code = cptw_pkg::REG_FACE;
    end
    r.deg = deg;
    return r;
  endfunction

  task automatic report(string what, logic [16:0] got, logic [16:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic query_t make_query(int c [12]);
    query_t q;
    foreach (c[i]) q.crd[i] = 16'(c[i]);
    q.has_exp = 1'b0;
    q.exp_a = '0; q.exp_b = '0; q.exp_c = '0; q.exp_reg = cptw_pkg::REG_A;
    q.exp_deg = 1'b0;
    return q;
  endfunction

  function automatic query_t with_exp(query_t q, logic [16:0] wa, logic [16:0] wb,
                                      logic [16:0] wc, cptw_pkg::region_t rg, bit dg);
    q.has_exp = 1'b1;
    q.exp_a = wa; q.exp_b = wb; q.exp_c = wc; q.exp_reg = rg; q.exp_deg = dg;
    return q;
  endfunction

  // random coordinate: small span, or full range when span is zero
  function automatic int rnd_coord(int span);
    if (span == 0) return int'($signed(16'($urandom)));
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // sender: bursts with random gaps, scoreboard on input transfers
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      if (cur.has_exp)
        weights_q.push_back('{cur.exp_a, cur.exp_b, cur.exp_c, cur.exp_reg, cur.exp_deg});
      else
        weights_q.push_back(predict_weights(cur));
    end
    if (rst_n && (!in_ch.valid || in_ch.ready)) begin
      if (gap_left > 0 || query_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        cur = query_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.a_x <= cur.crd[0]; in_ch.a_y <= cur.crd[1]; in_ch.a_z <= cur.crd[2];
        in_ch.b_x <= cur.crd[3]; in_ch.b_y <= cur.crd[4]; in_ch.b_z <= cur.crd[5];
        in_ch.c_x <= cur.crd[6]; in_ch.c_y <= cur.crd[7]; in_ch.c_z <= cur.crd[8];
        in_ch.p_x <= cur.crd[9]; in_ch.p_y <= cur.crd[10]; in_ch.p_z <= cur.crd[11];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = int'($urandom_range(1, 40));
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 30));
        end
      end
    end
  end

  // receiver: stall pattern that changes whenever the mode counter wraps
  always @(posedge clk) begin
    mode_cnt++;
    if (mode_cnt >= 200) begin
      mode_cnt = 0;
      stall_mode = int'($urandom_range(0, 3));
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 9) < 7);
      2: out_ch.ready <= ((mode_cnt % 37) > 20);
      default: out_ch.ready <= ($urandom_range(0, 9) < 2);
    endcase
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    weights_t w;
    if (out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (weights_q.size() == 0) begin
        $display("mismatch at %0t: result with nothing expected", $realtime);
        errors++;
      end else begin
        w = weights_q.pop_front();
        region_hits[w.reg_code]++;
        if (out_ch.weight_a !== w.wa) report("weight_a", out_ch.weight_a, w.wa);
        if (out_ch.weight_b !== w.wb) report("weight_b", out_ch.weight_b, w.wb);
        if (out_ch.weight_c !== w.wc) report("weight_c", out_ch.weight_c, w.wc);
        if (out_ch.region !== w.reg_code)
          report("region", 17'(out_ch.region), 17'(w.reg_code));
        if (out_ch.degenerate !== w.deg)
          report("degenerate", 17'(out_ch.degenerate), 17'(w.deg));
      end
    end
  end

  // stimulus and end of run
  initial begin
    query_t q;
    int     crd [12];
    int     span, kind;
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z} = '0;
    {in_ch.c_x, in_ch.c_y, in_ch.c_z, in_ch.p_x, in_ch.p_y, in_ch.p_z} = '0;
    crd = '{default: 0};
    cur = make_query(crd);

    // directed table
    foreach (dir_tab[i]) begin
      q = make_query(dir_tab[i].crd);
      if (dir_tab[i].has_exp)
        q = with_exp(q, dir_tab[i].wa, dir_tab[i].wb, dir_tab[i].wc, dir_tab[i].rg,
                     dir_tab[i].dg);
      query_q.push_back(q);
    end

    // random queries, mostly small triangles, some degenerate, some full range
    repeat (1032) begin
      kind = int'($urandom_range(0, 9));
      span = (kind < 6) ? 200 : (kind < 8) ? 0 : 40;
      foreach (crd[i]) crd[i] = rnd_coord(span);
      if (kind == 8) begin
        for (int i = 0; i < 3; i++) crd[6+i] = 2 * crd[3+i] - crd[i];
      end else if (kind == 9) begin
        case ($urandom_range(0, 2))
          0: for (int i = 0; i < 3; i++) crd[3+i] = crd[i];
          1: for (int i = 0; i < 3; i++) crd[6+i] = crd[i];
          default: for (int i = 0; i < 3; i++) crd[6+i] = crd[3+i];
        endcase
      end
      query_q.push_back(make_query(crd));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (query_q.size() == 0);
    @(posedge clk);
    while (in_ch.valid || weights_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("checked %0d results over directed and random triangles, with bursty input",
             results_seen);
    $display("regions a/b/ab/c/ac/bc/face: %0d %0d %0d %0d %0d %0d %0d", region_hits[0],
             region_hits[1], region_hits[2], region_hits[3], region_hits[4],
             region_hits[5], region_hits[6]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run time limit
  initial begin
    #4000000;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/cptw_pkg.sv
rtl/cptw_if.sv
rtl/cptw_front.sv
rtl/cptw_wmul.sv
rtl/cptw_region.sv
rtl/cptw_div.sv
rtl/closest_point_triangle_weights.sv
bench/testbench.sv
